@@ rtl/npcs_pkg.sv @@
package npcs_pkg;

    // palette size and derived widths
    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);

    // fixed field widths
    localparam int CHAN_W   = 8;
    localparam int IDX_W    = 8;
    localparam int COLOR_W  = 15;
    localparam int FIELD5_W = 5;
    localparam int NUM_CHAN = 3;
    localparam int ENTRY_W  = NUM_CHAN * CHAN_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int DIST_W   = 18;
    localparam int TDATA_W  = 48;

    // command codes carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    // widen a 5-bit field to 8 bits as (f << 3) + 4
    function automatic logic [CHAN_W-1:0] widen5(input logic [FIELD5_W-1:0] f);
        widen5 = {f, 3'b100};
    endfunction

endpackage

@@ rtl/nearest_palette_color_search.sv @@
// a load writes the palette memory; a query sweeps every slot through the pipelined read, difference,
//   square and compare registers, and its result is registered after the sweep, later only if
//   the previous result is still held; no new item is taken until that result is loaded
// the single read port is swept one entry per cycle; loads are taken one per cycle while idle
// reset: rst_n clears the sequencer and all valid flags; the palette memory is not cleared
module nearest_palette_color_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] entry_index, [15:8] entry_red, [23:16] entry_green, [31:24] entry_blue,
    // [46:32] query_color, [47] zero
    input  logic [npcs_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] nearest_index
    output logic [npcs_pkg::IDX_W-1:0]     m_axis_tdata
);
    import npcs_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    // input field split
    logic [IDX_W-1:0]   in_index;
    logic [ENTRY_W-1:0] in_entry;
    logic [COLOR_W-1:0] in_color;

    assign in_index = s_axis_tdata[IDX_W-1:0];
    assign in_entry = s_axis_tdata[IDX_W+ENTRY_W-1:IDX_W];
    assign in_color = s_axis_tdata[IDX_W+ENTRY_W+COLOR_W-1:IDX_W+ENTRY_W];

    // control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;

    // query color, widened
    logic [CHAN_W-1:0]   qc_reg [NUM_CHAN];
    logic [CHAN_W-1:0]   qc_next [NUM_CHAN];

    // distance pipeline
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                diff_valid_reg, diff_valid_next;
    logic [ADDR_W-1:0]   diff_addr_reg;
    logic [CHAN_W-1:0]   diff_reg [NUM_CHAN];
    logic [CHAN_W-1:0]   diff_next [NUM_CHAN];
    logic                sq_valid_reg, sq_valid_next;
    logic [ADDR_W-1:0]   sq_addr_reg;
    logic [SQ_W-1:0]     sq_reg [NUM_CHAN];
    logic [SQ_W-1:0]     sq_next [NUM_CHAN];

    // running best
    logic [DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic [ADDR_W-1:0]   best_addr_reg, best_addr_next;
    logic [DIST_W-1:0]   sum_dist;

    // sequencer strobes
    logic in_fire, query_fire, load_fire, issue, out_load, pipe_busy;

    logic [ENTRY_W-1:0]  palette_mem [PALETTE_ENTRIES];

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign query_fire = in_fire && (s_axis_tuser == CMD_QUERY);
    assign load_fire  = in_fire && (s_axis_tuser == CMD_LOAD)
                        && (int'(in_index) < PALETTE_ENTRIES);
    assign pipe_busy  = rd_valid_reg || diff_valid_reg || sq_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (addr_reg == LAST_ADDR)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!pipe_busy && (!out_valid_reg || m_axis_tready))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_SWEEP:
                issue = 1'b1;
            ST_FINISH:
                out_load = !pipe_busy && (!out_valid_reg || m_axis_tready);
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // address counter and query capture
    always_comb
    begin
        addr_next = addr_reg;
        if (query_fire)
            addr_next = '0;
        else if (issue)
            addr_next = addr_reg + ADDR_W'(1);
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            qc_next[c] = qc_reg[c];
            if (query_fire)
                qc_next[c] = widen5(in_color[c*FIELD5_W +: FIELD5_W]);
        end
    end

    // absolute channel differences and their squares
    always_comb
    begin
        diff_valid_next = rd_valid_reg;
        sq_valid_next   = diff_valid_reg;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (qc_reg[c] > rd_data_reg[c*CHAN_W +: CHAN_W])
                diff_next[c] = qc_reg[c] - rd_data_reg[c*CHAN_W +: CHAN_W];
            else
                diff_next[c] = rd_data_reg[c*CHAN_W +: CHAN_W] - qc_reg[c];
            sq_next[c] = SQ_W'(diff_reg[c]) * SQ_W'(diff_reg[c]);
        end
    end

    // sum and compare, lowest slot kept on ties
    always_comb
    begin
        sum_dist = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        best_dist_next = best_dist_reg;
        best_addr_next = best_addr_reg;
        if (query_fire)
        begin
            best_dist_next = '1;
            best_addr_next = '0;
        end
        else if (sq_valid_reg && (sum_dist < best_dist_reg))
        begin
            best_dist_next = sum_dist;
            best_addr_next = sq_addr_reg;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_index_next = IDX_W'(best_addr_reg);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_index_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= issue;
            diff_valid_reg <= diff_valid_next;
            sq_valid_reg   <= sq_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        rd_addr_reg   <= addr_reg;
        diff_addr_reg <= rd_addr_reg;
        sq_addr_reg   <= diff_addr_reg;
        best_dist_reg <= best_dist_next;
        best_addr_reg <= best_addr_next;
        out_index_reg <= out_index_next;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            qc_reg[c]   <= qc_next[c];
            diff_reg[c] <= diff_next[c];
            sq_reg[c]   <= sq_next[c];
        end
    end

    // palette memory write port
    always_ff @(posedge clk)
    begin
        if (load_fire)
            palette_mem[in_index[ADDR_W-1:0]] <= in_entry;
    end

    // palette memory read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= palette_mem[addr_reg];
    end

    // no new item while the distance pipeline still holds entries
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pipe_busy)
        else $error("input ready while distance pipeline busy");

    // a query starts the sweep at the first slot
    assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> (state_reg == ST_SWEEP) && (addr_reg == '0))
        else $error("query did not start sweep at slot zero");

    // memory reads come only from the sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SWEEP))
        else $error("palette read outside sweep");

    // a result appears only after the sweep has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH) && !pipe_busy)
        else $error("result raised before sweep finished");

endmodule

@@ bench/nearest_palette_color_search_checker.sv @@
module nearest_palette_color_search_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    // [7:0] entry_index, [15:8] entry_red, [23:16] entry_green, [31:24] entry_blue,
    // [46:32] query_color, [47] zero
    input  logic [npcs_pkg::TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                         s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] nearest_index
    input  logic [npcs_pkg::IDX_W-1:0]   m_axis_tdata,
    output int                           mismatches,
    output int                           pending
);
    import npcs_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [IDX_W-1:0]   nearest;
    } answer_t;

    // shadow copy of the palette, written by accepted loads
    rgb_t    palette_shadow [PALETTE_ENTRIES];
    answer_t nearest_q [$];
    int      mismatch_count = 0;

    initial
    begin
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            palette_shadow[i] = '0;
        end
    end

    // squared distance from the widened query to one palette slot
    function automatic int slot_distance(input logic [COLOR_W-1:0] color, input rgb_t slot);
        int q_red;
        int q_green;
        int q_blue;
        q_red   = (int'(color[4:0]) << 3) + 4;
        q_green = (int'(color[9:5]) << 3) + 4;
        q_blue  = (int'(color[14:10]) << 3) + 4;
        return (q_red - int'(slot.red)) * (q_red - int'(slot.red))
             + (q_green - int'(slot.green)) * (q_green - int'(slot.green))
             + (q_blue - int'(slot.blue)) * (q_blue - int'(slot.blue));
    endfunction

    // walk the palette, strict compare keeps the lowest slot on ties
    function automatic logic [IDX_W-1:0] find_nearest(input logic [COLOR_W-1:0] color);
        int                best_dist;
        int                slot_dist;
        logic [IDX_W-1:0]  best_slot;
        best_dist = 32'h7fff_ffff;
        best_slot = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            slot_dist = slot_distance(color, palette_shadow[i]);
            if (slot_dist < best_dist)
            begin
                best_dist = slot_dist;
                best_slot = IDX_W'(i);
            end
        end
        return best_slot;
    endfunction

    always @(posedge clk)
    begin
        answer_t oldest;
        rgb_t    loaded;
        if (rst_n)
        begin
            // accepted result against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (nearest_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: nearest_index %0d with nothing pending",
                                 m_axis_tdata);
                end
                else
                begin
                    oldest = nearest_q.pop_front();
                    if (m_axis_tdata !== oldest.nearest)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("nearest_index mismatch for query %h: expected %0d got %0d",
                                     oldest.color, oldest.nearest, m_axis_tdata);
                    end
                end
            end

            // accepted item: update palette or predict the answer
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == CMD_LOAD)
                begin
                    loaded.red   = s_axis_tdata[15:8];
                    loaded.green = s_axis_tdata[23:16];
                    loaded.blue  = s_axis_tdata[31:24];
                    if (int'(s_axis_tdata[7:0]) < PALETTE_ENTRIES)
                        palette_shadow[s_axis_tdata[7:0]] = loaded;
                end
                else
                begin
                    nearest_q.push_back('{color:   s_axis_tdata[46:32],
                                          nearest: find_nearest(s_axis_tdata[46:32])});
                end
            end
        end
        mismatches <= mismatch_count;
        pending    <= nearest_q.size();
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    import npcs_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // [7:0] entry_index, [15:8] entry_red, [23:16] entry_green, [31:24] entry_blue,
    // [46:32] query_color, [47] zero
    logic [TDATA_W-1:0] s_axis_tdata;
    // [0] command
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // [7:0] nearest_index
    logic [IDX_W-1:0]   m_axis_tdata;
    int                 mismatches;
    int                 pending;

    // small set of shared colors to force ties between slots
    logic [23:0]        tie_colors [8];
    int                 steady_items;

    nearest_palette_color_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nearest_palette_color_search_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [TDATA_W-1:0] pack_item(input logic [7:0] slot,
                                                     input logic [23:0] rgb,
                                                     input logic [14:0] color);
        return {1'b0, color, rgb[23:16], rgb[15:8], rgb[7:0], slot};
    endfunction

    // sender gap: mostly none or short, a few long, sometimes a stretch of none
    function automatic int sender_gap();
        int r;
        if (steady_items > 0)
        begin
            steady_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            steady_items = 40;
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one item through the slave channel, entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [TDATA_W-1:0] data);
        int gap;
        s_axis_tuser  = cmd;
        s_axis_tdata  = data;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        gap = sender_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic load_slot(input logic [7:0] slot, input logic [23:0] rgb,
                             input logic [14:0] ignored_color);
        send_item(CMD_LOAD, pack_item(slot, rgb, ignored_color));
    endtask

    task automatic query_color(input logic [14:0] color, input logic [31:0] ignored_entry);
        send_item(CMD_QUERY, pack_item(ignored_entry[7:0], ignored_entry[31:8], color));
    endtask

    // hold off the sender until every outstanding query has answered
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // random palette color: random, on the query grid, shared, or extreme
    function automatic logic [23:0] pick_rgb();
        int          r;
        logic [23:0] rgb;
        r = $urandom_range(0, 99);
        if (r < 40)
            rgb = 24'($urandom);
        else if (r < 70)
            rgb = {5'($urandom), 3'b100, 5'($urandom), 3'b100, 5'($urandom), 3'b100};
        else if (r < 90)
            rgb = tie_colors[$urandom_range(0, 7)];
        else
            rgb = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
        return rgb;
    endfunction

    function automatic logic [14:0] pick_query();
        int          r;
        logic [23:0] near;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 15'($urandom);
        if (r < 90)
            return {15{1'($urandom)}};
        // close to a shared color so that ties get exercised
        near = tie_colors[$urandom_range(0, 7)];
        return {near[23:19], near[15:11], near[7:3]};
    endfunction

    function automatic logic [7:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'd0;
        if (r < 10)
            return 8'hff;
        return 8'($urandom);
    endfunction

    // result side back-pressure
    initial
    begin
        int run;
        int stall;
        int r;
        m_axis_tready = 1'b1;
        forever
        begin
            r   = $urandom_range(0, 99);
            run = (r < 5) ? $urandom_range(200, 600) : $urandom_range(1, 8);
            m_axis_tready = 1'b1;
            repeat (run) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 40)
                stall = 0;
            else if (r < 85)
                stall = $urandom_range(1, 4);
            else if (r < 97)
                stall = $urandom_range(5, 30);
            else
                stall = $urandom_range(100, 400);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int r;
        steady_items  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        for (int i = 0; i < 8; i++)
        begin
            tie_colors[i] = 24'($urandom);
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every slot written before any query, all the same gray
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            load_slot(8'(i), 24'h808080, 15'h0);
        end

        // all slots tied, lowest must win
        query_color(15'h0000, 32'h0);
        query_color(15'h7fff, 32'hffff_ffff);

        // extremes, duplicate black, query field set on loads
        load_slot(8'd255, 24'hffffff, 15'h7fff);
        load_slot(8'd1, 24'h000000, 15'h0);
        load_slot(8'd200, 24'h000000, 15'h7fff);
        query_color(15'h7fff, 32'h0);
        query_color(15'h0000, 32'hffff_ffff);

        // one pure channel per slot, then the single-field queries
        load_slot(8'd7, 24'h0000ff, 15'h1234);
        load_slot(8'd8, 24'h00ff00, 15'h0);
        load_slot(8'd9, 24'hff0000, 15'h0);
        query_color(15'h001f, 32'h0);
        query_color(15'h03e0, 32'h0);
        query_color(15'h7c00, 32'h0);

        // exact grid hit gives zero distance
        load_slot(8'd3, {8'd252, 8'd20, 8'd12}, 15'h0);
        query_color({5'd31, 5'd2, 5'd1}, 32'h0);
        drain_results();

        // random part, with palette rewrites in shared colors now and then
        for (int n = 0; n < 1380; n++)
        begin
            if (n == 690)
                drain_results();
            r = $urandom_range(0, 999);
            if (r < 8)
            begin
                for (int k = 0; k < 24; k++)
                begin
                    load_slot(8'($urandom), tie_colors[$urandom_range(0, 7)], 15'($urandom));
                end
            end
            else if (r < 550)
                load_slot(pick_slot(), pick_rgb(), 15'($urandom));
            else
                query_color(pick_query(), $urandom);
        end
        s_axis_tvalid = 1'b0;

        wait (pending == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
